### hw/rtl/wcos_pkg.sv
// Shared types and constants for the weighted clock offset slew block.
// Used by wcos_div, wcos_mul and weighted_clock_offset_slew; no dependencies.
package wcos_pkg;

   localparam int MaxServers = 8;
   localparam logic [3:0] MaxCount = 4'(MaxServers);

   localparam logic [33:0] RttLimitReset = 34'd9999000000;

   localparam logic [6:0] DivStepsWeight = 7'd25;
   localparam logic [6:0] DivStepsMean   = 7'd64;
   localparam logic [6:0] DivStepsFrac   = 7'd16;
   localparam logic [4:0] MulSteps       = 5'd25;

   localparam logic [24:0] FracOne = 25'h10000;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_QUERY   = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_SLEW  = 1'b0,
      REG_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WDIV,
      ST_WMUL,
      ST_LAST,
      ST_MDIV,
      ST_FDIV,
      ST_SMUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        go;
      logic [33:0] rem;
      logic [63:0] num;
      logic [6:0]  steps;
      logic [33:0] den;
   } div_start_type;

   typedef struct packed {
      logic        go;
      logic [36:0] mcand;
      logic [24:0] mplier;
   } mul_start_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

### hw/rtl/wcos_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wcos_pkg for the start request and status structs.
module wcos_div
   import wcos_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  div_start_type   start,
   output unit_status_type status,
   output logic [63:0]     quotient,
   output logic [33:0]     remainder
);

   logic        busy_ff, done_ff;
   logic [6:0]  cnt_ff;
   logic [33:0] rem_ff, den_ff;
   logic [63:0] quo_ff;
   logic [34:0] trial, diff;
   logic        ge;

   assign trial = {rem_ff, quo_ff[63]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= start.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start.go) begin
         rem_ff <= start.rem;
         quo_ff <= start.num;
         den_ff <= start.den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[33:0] : trial[33:0];
         quo_ff <= {quo_ff[62:0], ge};
      end
   end

   assign status    = '{busy: busy_ff, done: done_ff};
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/wcos_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on wcos_pkg for the start request and status structs.
module wcos_mul
   import wcos_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  mul_start_type   start,
   output unit_status_type status,
   output logic [61:0]     product
);

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [61:0] acc_ff, a_ff;
   logic [24:0] b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MulSteps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start.go) begin
         acc_ff <= '0;
         a_ff   <= {25'd0, start.mcand};
         b_ff   <= start.mplier;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= {a_ff[60:0], 1'b0};
         b_ff <= {1'b0, b_ff[24:1]};
      end
   end

   assign status  = '{busy: busy_ff, done: done_ff};
   assign product = acc_ff;

endmodule

### hw/rtl/weighted_clock_offset_slew.sv
// Weighted clock offset combiner with slewed offset, top level.
// Sample: a counted one runs a 25-step weight divide and, for a nonzero weight, a 25-step
// multiply; the last of a round adds the mean divide when the weight sum is nonzero.
// Query: straight to output with slew 0, else a multiply, after a 16-step fraction divide
// for a partial step. One request at a time; a result waits in its own register. Reset is
// synchronous active-high; clears real/smooth/origin offsets, origin/query times, sums, FSM.
module weighted_clock_offset_slew
   import wcos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,  // offset_us[35:0], rtt_us[69:36], now_us[117:70]
   input  logic [1:0]    req_tuser,  // op[1:0]
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,  // real_time_us[49:0], smooth_time_us[99:50]
   input  logic          csr_we,
   input  logic [0:0]    csr_index,
   input  logic [33:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic [31:0] slew_ff;
   logic [33:0] limit_ff;
   logic signed [35:0] real_ff, smooth_ff, origin_off_ff;
   logic [47:0] origin_time_ff, lqt_ff;
   logic [27:0] wt_ff;
   logic [63:0] wot_ff;
   logic [3:0]  cnt_ff;
   logic [35:0] off_ff;
   logic [47:0] now_ff;
   logic        last_ff;
   logic [24:0] w_ff;
   logic        rsp_valid_ff;
   logic [103:0] rsp_data_ff;

   div_start_type   div_start;
   mul_start_type   mul_start;
   unit_status_type div_st, mul_st;
   logic [63:0] quo;
   logic [33:0] rem;
   logic [61:0] prod;

   logic        accept;
   op_type      req_op;
   logic [35:0] req_off;
   logic [33:0] req_rtt;
   logic [47:0] req_now, delta;
   logic        counts;
   logic [35:0] off_mag;
   logic [36:0] diff, diff_mag;
   logic [63:0] wot_mag, mean_q;
   logic [35:0] mean;
   logic [36:0] step, smooth_next;
   logic [61:0] prod_rnd;
   logic        out_free;
   logic [49:0] elapsed, rt, st;

   assign req_op  = op_type'(req_tuser);
   assign req_off = req_tdata[35:0];
   assign req_rtt = req_tdata[69:36];
   assign req_now = req_tdata[117:70];
   assign accept  = req_tvalid && req_tready;
   assign delta   = req_now - lqt_ff;
   assign counts  = (req_rtt < limit_ff) && (cnt_ff < MaxCount);

   assign off_mag  = off_ff[35] ? 36'(-off_ff) : off_ff;
   assign diff     = {real_ff[35], real_ff} - {smooth_ff[35], smooth_ff};
   assign diff_mag = diff[36] ? -diff : diff;
   assign wot_mag  = wot_ff[63] ? -wot_ff : wot_ff;
   assign mean_q   = quo + 64'({rem, 1'b0} >= {1'b0, 6'd0, wt_ff});
   assign mean     = wot_ff[63] ? 36'(-mean_q) : mean_q[35:0];
   assign prod_rnd = prod + 62'd32768;
   assign step     = prod_rnd[52:16];
   assign smooth_next = diff[36] ? {smooth_ff[35], smooth_ff} - step
                                 : {smooth_ff[35], smooth_ff} + step;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign elapsed  = {2'b00, now_ff - origin_time_ff};
   assign rt = elapsed + 50'(real_ff) - 50'(origin_off_ff);
   assign st = elapsed + 50'(smooth_ff) - 50'(origin_off_ff);

   wcos_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .status(div_st),
      .quotient(quo), .remainder(rem)
   );

   wcos_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .status(mul_st), .product(prod)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_SAMPLE: state_in = counts ? ST_WDIV : ST_LAST;
                  OP_QUERY: begin
                     if (slew_ff == 32'd0) state_in = ST_OUT;
                     else if (delta >= {16'd0, slew_ff}) state_in = ST_SMUL;
                     else state_in = ST_FDIV;
                  end
                  OP_RESTART, OP_NONE: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WDIV: if (div_st.done) state_in = (quo[24:0] != 25'd0) ? ST_WMUL : ST_LAST;
         ST_WMUL: if (mul_st.done) state_in = ST_LAST;
         ST_LAST: state_in = (last_ff && wt_ff != 28'd0) ? ST_MDIV : ST_IDLE;
         ST_MDIV: if (div_st.done) state_in = ST_IDLE;
         ST_FDIV: if (div_st.done) state_in = ST_SMUL;
         ST_SMUL: if (mul_st.done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = state_ff == ST_IDLE;
      div_start  = '0;
      mul_start  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_SAMPLE && counts) begin
               div_start.go    = 1'b1;
               div_start.num   = 64'h8000_0000_0000_0000;
               div_start.steps = DivStepsWeight;
               div_start.den   = (req_rtt == 34'd0) ? 34'd1 : req_rtt;
            end
            if (accept && req_op == OP_QUERY && slew_ff != 32'd0) begin
               if (delta >= {16'd0, slew_ff}) begin
                  mul_start.go     = 1'b1;
                  mul_start.mcand  = diff_mag;
                  mul_start.mplier = FracOne;
               end else begin
                  div_start.go    = 1'b1;
                  div_start.rem   = {2'b00, delta[31:0]};
                  div_start.steps = DivStepsFrac;
                  div_start.den   = {2'b00, slew_ff};
               end
            end
         end
         ST_WDIV: begin
            if (div_st.done && quo[24:0] != 25'd0) begin
               mul_start.go     = 1'b1;
               mul_start.mcand  = {1'b0, off_mag};
               mul_start.mplier = quo[24:0];
            end
         end
         ST_LAST: begin
            if (last_ff && wt_ff != 28'd0) begin
               div_start.go    = 1'b1;
               div_start.num   = wot_mag;
               div_start.steps = DivStepsMean;
               div_start.den   = {6'd0, wt_ff};
            end
         end
         ST_FDIV: begin
            if (div_st.done) begin
               mul_start.go     = 1'b1;
               mul_start.mcand  = diff_mag;
               mul_start.mplier = {9'd0, quo[15:0]};
            end
         end
         ST_WMUL, ST_MDIV, ST_SMUL, ST_OUT: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slew_ff        <= '0;
         limit_ff       <= RttLimitReset;
         real_ff        <= '0;
         smooth_ff      <= '0;
         origin_off_ff  <= '0;
         origin_time_ff <= '0;
         lqt_ff         <= '0;
         wt_ff          <= '0;
         wot_ff         <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_SLEW:  slew_ff  <= csr_wdata[31:0];
               REG_LIMIT: limit_ff <= csr_wdata;
            endcase
         end
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_op == OP_QUERY) begin
                  lqt_ff <= req_now;
                  if (slew_ff == 32'd0) smooth_ff <= real_ff;
               end
               if (accept && req_op == OP_RESTART) begin
                  origin_time_ff <= req_now;
                  origin_off_ff  <= real_ff;
               end
            end
            ST_WDIV: if (div_st.done) cnt_ff <= cnt_ff + 4'd1;
            ST_WMUL: begin
               if (mul_st.done) begin
                  wt_ff  <= wt_ff + {3'd0, w_ff};
                  wot_ff <= off_ff[35] ? wot_ff - {2'b00, prod} : wot_ff + {2'b00, prod};
               end
            end
            ST_LAST: begin
               if (last_ff && wt_ff == 28'd0) begin
                  wot_ff <= '0;
                  cnt_ff <= '0;
               end
            end
            ST_MDIV: begin
               if (div_st.done) begin
                  real_ff <= mean;
                  if (origin_off_ff == 36'sd0) begin
                     origin_off_ff <= mean;
                     smooth_ff     <= mean;
                  end
                  wt_ff  <= '0;
                  wot_ff <= '0;
                  cnt_ff <= '0;
               end
            end
            ST_SMUL: if (mul_st.done) smooth_ff <= smooth_next[35:0];
            ST_OUT, ST_FDIV: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         off_ff  <= req_off;
         now_ff  <= req_now;
         last_ff <= req_tlast;
      end
      if (state_ff == ST_WDIV && div_st.done) w_ff <= quo[24:0];
      if (state_ff == ST_OUT && out_free) rsp_data_ff <= {4'd0, st, rt};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_st.busy && mul_st.busy))
      else $error("divider and multiplier busy together");

   a_ready_idle_units: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_st.busy && !mul_st.busy)
      else $error("request taken while a unit is busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MaxCount)
      else $error("sample count above server limit");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_tvalid && state_ff == ST_IDLE)
      else $error("result not presented after query");

endmodule

### tb/tb_weighted_clock_offset_slew.sv
// Self-checking testbench for weighted_clock_offset_slew: directed and random
// sample rounds, queries and restarts under several register settings.
// Depends on wcos_pkg and the weighted_clock_offset_slew RTL.
module tb_weighted_clock_offset_slew;
   import wcos_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [47:0] TimeMask = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [49:0] real_us;
      logic [49:0] smooth_us;
   } clock_reading_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [119:0]  req_tdata = '0;
   logic [1:0]    req_tuser = OP_NONE;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [0:0]    csr_index = REG_SLEW;
   logic [33:0]   csr_wdata = '0;

   weighted_clock_offset_slew uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0]        slew_cfg = '0;
   logic [33:0]        limit_cfg = RttLimitReset;
   logic signed [63:0] real_ofs = 0, smooth_ofs = 0, origin_ofs = 0;
   logic [47:0]        origin_t = '0, last_query_t = '0, clock_now = '0;
   logic [27:0]        weight_sum = '0;
   logic [63:0]        weighted_sum = '0;
   int unsigned        counted = 0;

   clock_reading_type  pending_readings[$];
   int unsigned        errors = 0, requests = 0, readings = 0;
   bit                 no_gaps = 1'b0, rsp_eager = 1'b0;

   function automatic void predict_request(logic [1:0] op, logic [35:0] ofs, logic [33:0] rtt,
                                           logic last, logic [47:0] now);
      logic [33:0]        w;
      logic [63:0]        mag, q, r, frac, dlt, elapsed;
      logic signed [63:0] diff, mean;
      bit                 neg;
      clock_reading_type  rd;
      if (op == OP_SAMPLE) begin
         if (rtt < limit_cfg && counted < MaxServers) begin
            w = 34'(25'h100_0000 / (rtt == 0 ? 34'd1 : rtt));
            counted++;
            if (w != 0) begin
               weight_sum += 28'(w);
               weighted_sum += 64'($signed({{28{ofs[35]}}, ofs}) * $signed({30'b0, w}));
            end
         end
         if (last) begin
            if (weight_sum != 0) begin
               neg = weighted_sum[63];
               mag = neg ? -weighted_sum : weighted_sum;
               q = mag / weight_sum;
               r = mag % weight_sum;
               if (r >= weight_sum - r) q++;
               mean = neg ? -$signed(q) : $signed(q);
               real_ofs = mean;
               if (origin_ofs == 0) begin
                  origin_ofs = mean;
                  smooth_ofs = mean;
               end
            end
            weight_sum = '0;
            weighted_sum = '0;
            counted = 0;
         end
      end else if (op == OP_RESTART) begin
         origin_t = now;
         origin_ofs = real_ofs;
      end else if (op == OP_QUERY) begin
         dlt = 64'(48'(now - last_query_t));
         elapsed = 64'(48'(now - origin_t));
         last_query_t = now;
         if (slew_cfg == 0) begin
            smooth_ofs = real_ofs;
         end else begin
            frac = (dlt >= slew_cfg) ? 64'd65536 : (dlt << 16) / slew_cfg;
            diff = real_ofs - smooth_ofs;
            mag = (diff < 0 ? -diff : diff) * frac;
            mag = (mag + 64'd32768) >> 16;
            smooth_ofs = diff < 0 ? smooth_ofs - $signed(mag) : smooth_ofs + $signed(mag);
         end
         rd.real_us = 50'($signed(elapsed) + real_ofs - origin_ofs);
         rd.smooth_us = 50'($signed(elapsed) + smooth_ofs - origin_ofs);
         pending_readings.push_back(rd);
      end
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 19);
      if (no_gaps || k < 10) return 0;
      if (k < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(logic [1:0] op, logic [35:0] ofs, logic [33:0] rtt,
                               logic last, logic [47:0] now);
      int g;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tlast <= last;
      req_tdata <= {2'b00, now, rtt, ofs};
      do @(posedge clock); while (!req_tready);
      predict_request(op, ofs, rtt, last, now);
      requests++;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [33:0] value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_SLEW) slew_cfg = value[31:0];
      else limit_cfg = value;
   endtask

   function automatic logic [33:0] random_rtt();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 34'($urandom_range(1, 100));
         2: return 34'($urandom_range(1, 32'h100_0000));
         3: return 34'($urandom_range(32'h100_0001, 32'hFFFF_FFFF));
         4: return 34'({$urandom, $urandom});
         5: return limit_cfg + 34'($urandom_range(0, 2)) - 34'd1;
         default: return 34'($urandom_range(1, 5000));
      endcase
   endfunction

   function automatic logic [35:0] random_offset();
      if ($urandom_range(0, 3) == 0) return 36'({$urandom, $urandom});
      return 36'($signed($urandom_range(0, 2000000)) - 1000000);
   endfunction

   function automatic logic [47:0] next_time();
      if ($urandom_range(0, 9) == 0) clock_now = 48'({$urandom, $urandom});
      else clock_now += 48'($urandom_range(0, 3000000));
      return clock_now;
   endfunction

   task automatic test_directed();
      send_request(OP_QUERY, '0, '0, 1'b0, 48'd0);
      send_request(OP_SAMPLE, 36'h8_0000_0000, 34'd0, 1'b0, '0);
      send_request(OP_SAMPLE, 36'h7_FFFF_FFFF, 34'd1, 1'b0, '1);
      send_request(OP_SAMPLE, 36'd12345, 34'd300000000, 1'b1, '0);
      send_request(OP_QUERY, '0, '0, 1'b0, 48'd1000);
      send_request(OP_SAMPLE, 36'd55, 34'h3_FFFF_FFFF, 1'b1, '0);
      send_request(OP_SAMPLE, 36'd77, 34'd9999000000, 1'b1, '0);
      for (int i = 0; i < 10; i++)
         send_request(OP_SAMPLE, 36'(i * 1000 - 3000), 34'(i + 1), i == 9, '0);
      send_request(OP_NONE, '1, '1, 1'b1, '1);
      send_request(OP_RESTART, '0, '0, 1'b0, TimeMask);
      send_request(OP_QUERY, '0, '0, 1'b0, 48'd5);
      send_request(OP_QUERY, '1, '1, 1'b1, TimeMask);
   endtask

   task automatic test_random_traffic(int n);
      int kind, round_len, cnt;
      cnt = 0;
      while (cnt < n) begin
         kind = $urandom_range(0, 19);
         if (kind < 11) begin
            round_len = $urandom_range(1, 10);
            for (int i = 0; i < round_len; i++)
               send_request(OP_SAMPLE, random_offset(), random_rtt(), i == round_len - 1,
                            48'({$urandom, $urandom}));
            cnt += round_len;
         end else if (kind < 18) begin
            send_request(OP_QUERY, random_offset(), random_rtt(), 1'($urandom),
                         next_time());
            cnt++;
         end else if (kind == 18) begin
            send_request(OP_RESTART, random_offset(), random_rtt(), 1'($urandom),
                         next_time());
            cnt++;
         end else begin
            send_request(2'($urandom_range(0, 3)), random_offset(), random_rtt(),
                         1'($urandom), 48'({$urandom, $urandom}));
            cnt++;
         end
      end
   endtask

   task automatic test_slew_settings();
      write_csr(REG_SLEW, 34'd1);
      test_random_traffic(60);
      write_csr(REG_SLEW, 34'd1000000);
      test_random_traffic(100);
      write_csr(REG_SLEW, 34'hFFFF_FFFF);
      test_random_traffic(60);
      write_csr(REG_SLEW, 34'($urandom));
      test_random_traffic(60);
   endtask

   task automatic test_limit_settings();
      write_csr(REG_LIMIT, 34'd0);
      test_random_traffic(30);
      write_csr(REG_LIMIT, 34'h3_FFFF_FFFF);
      test_random_traffic(80);
      write_csr(REG_LIMIT, 34'd1000);
      test_random_traffic(60);
      write_csr(REG_SLEW, 34'd0);
      write_csr(REG_LIMIT, RttLimitReset);
      no_gaps = 1'b1;
      rsp_eager = 1'b1;
      test_random_traffic(80);
      no_gaps = 1'b0;
      rsp_eager = 1'b0;
      test_random_traffic(100);
   endtask

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (rsp_eager) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 19) == 0) begin
            hold = $urandom_range(10, 50);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(0, 3) != 0;
         end
      end
   end

   always @(posedge clock) begin
      clock_reading_type rd;
      if (!reset && rsp_tvalid && rsp_tready) begin
         readings++;
         if (pending_readings.size() == 0) begin
            errors++;
            $display("%0t unexpected result: actual %h", $realtime, rsp_tdata);
         end else begin
            rd = pending_readings.pop_front();
            if (rsp_tdata[49:0] !== rd.real_us) begin
               errors++;
               $display("%0t real time mismatch: expected %h actual %h",
                        $realtime, rd.real_us, rsp_tdata[49:0]);
            end
            if (rsp_tdata[99:50] !== rd.smooth_us) begin
               errors++;
               $display("%0t smoothed time mismatch: expected %h actual %h",
                        $realtime, rd.smooth_us, rsp_tdata[99:50]);
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_slew_settings();
      test_limit_settings();
      drain();
      $display("Sent %0d requests and checked %0d time readings across slew and rtt limit",
               requests, readings);
      $display("settings including zero and maximum values.");
      if (errors == 0 && pending_readings.size() == 0) begin
         $display("PASS weighted_clock_offset_slew");
      end else begin
         $display("FAIL weighted_clock_offset_slew");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL weighted_clock_offset_slew");
      $finish;
   end
endmodule
